[sv/per_seed_top_k_tracker_top_assert.svh]
// Assertion macros shared by the tracker modules
`ifndef PER_SEED_TOP_K_TRACKER_TOP_ASSERT_SVH
`define PER_SEED_TOP_K_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PTK_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ptk assertion failed");
`define PTK_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ptk assertion failed");
`else
`define PTK_ASSERT(name, prop)
`define PTK_ASSERT_ALWAYS(name, prop)
`endif

`endif

[sv/ptk_pkg.sv]
// Types, constants and helper functions for the per-seed top-k tracker
package ptk_pkg;

  localparam int MAX_K     = 16;
  localparam int MAX_SEEDS = 4;
  localparam int IDX_W     = $clog2(MAX_K);
  localparam int FILL_W    = $clog2(MAX_K + 1);
  localparam int SEED_W    = 2;
  localparam int NUM_CLASSES = 2;
  localparam logic [31:0] CLASS_BIT = 32'h8000_0000;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_DUMP  = 1'b1;

  localparam logic REG_TOP_K      = 1'b0;
  localparam logic REG_SEED_COUNT = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] score;
  } entry_t;

  typedef struct packed {
    logic             cls;
    logic [IDX_W-1:0] idx;
  } rd_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } dump_state_t;

  // a ranks strictly ahead of b
  function automatic logic better(entry_t a, entry_t b);
    better = (a.score > b.score) || ((a.score == b.score) && (a.id > b.id));
  endfunction

  function automatic logic [FILL_W-1:0] eff_k(logic [4:0] v);
    logic [FILL_W-1:0] r;
    if (v == 5'd0) begin
      r = FILL_W'(1);
    end else if (32'(v) > MAX_K) begin
      r = FILL_W'(MAX_K);
    end else begin
      r = FILL_W'(v);
    end
    eff_k = r;
  endfunction

  function automatic logic [2:0] eff_seeds(logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (32'(v) > MAX_SEEDS) begin
      r = 3'(MAX_SEEDS);
    end else begin
      r = v;
    end
    eff_seeds = r;
  endfunction

endpackage

[sv/ptk_lane.sv]
// One seed lane: sorted insertion cells for both classes and their fill counts
`include "per_seed_top_k_tracker_top_assert.svh"

module ptk_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       offer,
  input  logic [31:0]                vertex_id,
  input  logic [31:0]                score,
  input  logic [ptk_pkg::FILL_W-1:0] k,
  input  ptk_pkg::rd_req_t           rd,
  output ptk_pkg::entry_t            rd_entry,
  output logic [ptk_pkg::FILL_W-1:0] rd_fill
);
  import ptk_pkg::*;

  entry_t            cells [NUM_CLASSES][MAX_K];
  logic [FILL_W-1:0] fill  [NUM_CLASSES];

  logic              cls;
  entry_t            new_entry;
  logic [FILL_W-1:0] len;
  logic [MAX_K-1:0]  ge;
  entry_t            row_next [MAX_K];
  logic [FILL_W-1:0] fill_next;

  always_comb begin
    cls = (vertex_id & CLASS_BIT) != 32'd0;
    new_entry.id = vertex_id;
    new_entry.score = score;
    len = (fill[cls] > k) ? k : fill[cls];
    // stored entries that stay ahead of the newcomer form a prefix
    for (int i = 0; i < MAX_K; i++) begin
      ge[i] = (FILL_W'(i) < len) && !better(new_entry, cells[cls][i]);
    end
    row_next[0] = ge[0] ? cells[cls][0] : new_entry;
    for (int i = 1; i < MAX_K; i++) begin
      if (ge[i]) begin
        row_next[i] = cells[cls][i];
      end else if (ge[i-1]) begin
        row_next[i] = new_entry;
      end else begin
        row_next[i] = cells[cls][i-1];
      end
    end
    // a full list keeps its length; a rejected entry only lands past the fill
    fill_next = (len < k) ? len + FILL_W'(1) : len;
  end

  always_ff @(posedge clk) begin
    if (offer) begin
      for (int i = 0; i < MAX_K; i++) begin
        cells[cls][i] <= row_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        fill[c] <= '0;
      end
    end else if (offer) begin
      fill[cls] <= fill_next;
    end
  end

  assign rd_entry = cells[rd.cls][rd.idx];
  assign rd_fill  = fill[rd.cls];

  `PTK_ASSERT(a_fill0_bound, fill[0] <= FILL_W'(MAX_K))
  `PTK_ASSERT(a_fill1_bound, fill[1] <= FILL_W'(MAX_K))
  `PTK_ASSERT(a_fill_grow,
    (offer && !cls && fill[0] < k) |=> fill[0] == $past(fill[0]) + FILL_W'(1))

endmodule

[sv/ptk_dump.sv]
// Dump sequencer: merges the lane read ports and emits one list best-first
`include "per_seed_top_k_tracker_top_assert.svh"

module ptk_dump (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       dump_go,
  input  logic                       dump_class,
  input  logic [ptk_pkg::SEED_W-1:0] dump_seed,
  input  logic [ptk_pkg::FILL_W-1:0] k,
  input  ptk_pkg::entry_t            lane_entry [ptk_pkg::MAX_SEEDS],
  input  logic [ptk_pkg::FILL_W-1:0] lane_fill  [ptk_pkg::MAX_SEEDS],
  output ptk_pkg::rd_req_t           rd,
  output logic                       busy,
  output logic                       result_valid,
  output logic [31:0]                entry_id,
  output logic [31:0]                entry_score,
  output logic [3:0]                 entry_rank,
  output logic                       list_empty,
  output logic                       last
);
  import ptk_pkg::*;

  dump_state_t       state, state_next;
  logic              cls;
  logic [SEED_W-1:0] seed;
  logic [IDX_W-1:0]  idx, idx_next;

  logic [FILL_W-1:0] len;
  entry_t            sel_entry;
  logic              emit, emit_last, emit_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dump_go) begin
      cls  <= dump_class;
      seed <= dump_seed;
    end
  end

  always_comb begin
    len = (lane_fill[seed] > k) ? k : lane_fill[seed];
    sel_entry = lane_entry[seed];
    state_next = state;
    idx_next = idx;
    emit = 1'b0;
    emit_last = 1'b0;
    emit_empty = 1'b0;
    case (state)
      ST_IDLE: begin
        if (dump_go) begin
          state_next = ST_EMIT;
          idx_next = '0;
        end
      end
      ST_EMIT: begin
        emit = 1'b1;
        if (len == '0) begin
          emit_empty = 1'b1;
          emit_last = 1'b1;
          state_next = ST_IDLE;
        end else begin
          emit_last = ({1'b0, idx} + FILL_W'(1)) == len;
          idx_next = idx + IDX_W'(1);
          if (emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd.cls = cls;
  assign rd.idx = idx;
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      entry_id    <= emit_empty ? 32'd0 : sel_entry.id;
      entry_score <= emit_empty ? 32'd0 : sel_entry.score;
      entry_rank  <= emit_empty ? 4'd0 : 4'(idx);
      list_empty  <= emit_empty;
      last        <= emit_last;
    end
  end

  `PTK_ASSERT(a_burst_unbroken, (result_valid && !last) |=> result_valid)
  `PTK_ASSERT(a_rank_steps,
    (result_valid && !last) |=> entry_rank == 4'($past(entry_rank) + 4'd1))
  `PTK_ASSERT(a_empty_single, (result_valid && list_empty) |-> (last && entry_rank == 4'd0))
  `PTK_ASSERT_ALWAYS(a_idle_after_last, (result_valid && last) |-> state == ST_IDLE)

endmodule

[sv/per_seed_top_k_tracker_top.sv]
// Top level of the per-seed top-k tracker: register port, seed lanes and dump sequencer
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+------------------------------------------
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata (top_k, seed_count)
//  command  | start, busy                       | kind, vertex_id, score_lane0..3,
//           |                                   | dump_class, dump_seed
//  result   | result_valid                      | entry_id, entry_score, entry_rank,
//           |                                   | list_empty, last
//
// On an offer every active lane inserts its score into its sorted cells in parallel, and
// busy stays low. A dump emits the list best-first, a single list_empty result for an empty
// list, as the sequencer reads one cell per cycle through the lane read ports.
// Reset clears the fill counts; cell contents need no clearing.
// Results appear one per cycle with no gaps and cannot be held off by the receiver.

module per_seed_top_k_tracker_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic [31:0]                vertex_id,
  input  logic [31:0]                score_lane0,
  input  logic [31:0]                score_lane1,
  input  logic [31:0]                score_lane2,
  input  logic [31:0]                score_lane3,
  input  logic                       dump_class,
  input  logic [ptk_pkg::SEED_W-1:0] dump_seed,
  output logic                       result_valid,
  output logic [31:0]                entry_id,
  output logic [31:0]                entry_score,
  output logic [3:0]                 entry_rank,
  output logic                       list_empty,
  output logic                       last
);
  import ptk_pkg::*;

  logic [4:0]        top_k;
  logic [2:0]        seed_count;
  logic [FILL_W-1:0] k_eff;
  logic [2:0]        seeds_eff;

  logic              accept;
  logic              offer_go, dump_go;
  logic [31:0]       scores     [MAX_SEEDS];
  entry_t            lane_entry [MAX_SEEDS];
  logic [FILL_W-1:0] lane_fill  [MAX_SEEDS];
  rd_req_t           rd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_k      <= 5'd16;
      seed_count <= 3'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TOP_K:      top_k      <= pwdata[4:0];
        REG_SEED_COUNT: seed_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOP_K:      prdata = {27'd0, top_k};
      REG_SEED_COUNT: prdata = {29'd0, seed_count};
      default:        prdata = 32'd0;
    endcase
  end

  assign k_eff     = eff_k(top_k);
  assign seeds_eff = eff_seeds(seed_count);

  assign accept   = start && !busy;
  assign offer_go = accept && (kind == KIND_OFFER);
  assign dump_go  = accept && (kind == KIND_DUMP);

  assign scores[0] = score_lane0;
  assign scores[1] = score_lane1;
  assign scores[2] = score_lane2;
  assign scores[3] = score_lane3;

  for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_lane
    ptk_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .offer     (offer_go && (32'(g) < 32'(seeds_eff))),
      .vertex_id (vertex_id),
      .score     (scores[g]),
      .k         (k_eff),
      .rd        (rd),
      .rd_entry  (lane_entry[g]),
      .rd_fill   (lane_fill[g])
    );
  end

  ptk_dump u_dump (
    .clk          (clk),
    .rst          (rst),
    .dump_go      (dump_go),
    .dump_class   (dump_class),
    .dump_seed    (dump_seed),
    .k            (k_eff),
    .lane_entry   (lane_entry),
    .lane_fill    (lane_fill),
    .rd           (rd),
    .busy         (busy),
    .result_valid (result_valid),
    .entry_id     (entry_id),
    .entry_score  (entry_score),
    .entry_rank   (entry_rank),
    .list_empty   (list_empty),
    .last         (last)
  );

endmodule
